FILE: rtl/core/twrc_pkg.sv
package twrc_pkg;

	localparam int NODE_MAX   = 8;
	localparam int PLAYER_MAX = 8;
	localparam int RING_DEPTH = 16;
	localparam int NODE_W     = $clog2(NODE_MAX);
	localparam int PLAYER_W   = $clog2(PLAYER_MAX);
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int TIC_W      = 31;
	localparam int XTIC_W     = TIC_W + 2;
	localparam int CNT_NODE_W = 4;
	localparam int CD_W       = 4;
	localparam logic [CD_W-1:0] RELOAD = CD_W'(10);
	localparam int WINDOW     = 64;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		V_SETUP   = 3'd0,
		V_LEFT    = 3'd1,
		V_GONE    = 3'd2,
		V_KILL    = 3'd3,
		V_DUP     = 3'd4,
		V_ORDER   = 3'd5,
		V_MISSED  = 3'd6,
		V_ACCEPT  = 3'd7
	} verdict_t;

	typedef enum logic [1:0] {
		K_SETUP  = 2'd0,
		K_EXIT   = 2'd1,
		K_KILL   = 2'd2,
		K_NORMAL = 2'd3
	} kind_t;

	// classified header, front to back
	typedef struct packed {
		kind_t                     kind;
		logic [NODE_W-1:0]         node;
		logic [PLAYER_W-1:0]       player;
		logic                      retransmit;
		logic signed [XTIC_W-1:0]  rstart;
		logic signed [XTIC_W-1:0]  rend;
		logic [TIC_W-1:0]          retr_tic;
	} item_t;

	typedef struct packed {
		verdict_t          verdict;
		logic [TIC_W-1:0]  expanded_start;
		logic [7:0]        skip_count;
		logic [7:0]        take_count;
		logic [SLOT_W-1:0] first_slot;
		logic [TIC_W-1:0]  resend_from;
		logic              resend_latched;
		logic              resend_needed;
	} result_t;

	// expand a tic low byte to a full tic within +/- WINDOW of the local tic
	function automatic logic signed [XTIC_W-1:0] expand_tic(
		input logic [7:0]       low,
		input logic [TIC_W-1:0] local_t
	);
		logic signed [XTIC_W-1:0] base;
		logic signed [XTIC_W-1:0] lo;
		logic signed [9:0]        delta;
		base  = $signed({2'b00, local_t[TIC_W-1:8], 8'h00});
		lo    = $signed({{(XTIC_W-8){1'b0}}, low});
		delta = $signed({2'b00, low}) - $signed({2'b00, local_t[7:0]});
		if (delta > 10'sd64) begin
			return base + lo - XTIC_W'(256);
		end else if (delta < -10'sd64) begin
			return base + lo + XTIC_W'(256);
		end
		return base + lo;
	endfunction

endpackage

FILE: rtl/core/twrc_front.sv
module twrc_front (
	input  logic                               flag_setup,
	input  logic                               flag_exit,
	input  logic                               flag_kill,
	input  logic                               flag_retransmit,
	input  logic [twrc_pkg::NODE_W-1:0]        node,
	input  logic [twrc_pkg::PLAYER_W-1:0]      player,
	input  logic [7:0]                         start_tic_low,
	input  logic [7:0]                         tic_count,
	input  logic [7:0]                         retransmit_low,
	input  logic [twrc_pkg::TIC_W-1:0]         local_tic,
	output twrc_pkg::item_t                    item
);

	logic signed [twrc_pkg::XTIC_W-1:0] rstart;
	logic signed [twrc_pkg::XTIC_W-1:0] rretr;

	always_comb begin
		rstart = twrc_pkg::expand_tic(start_tic_low, local_tic);
		rretr  = twrc_pkg::expand_tic(retransmit_low, local_tic);

		// setup wins over exit, exit over kill
		if (flag_setup) begin
			item.kind = twrc_pkg::K_SETUP;
		end else if (flag_exit) begin
			item.kind = twrc_pkg::K_EXIT;
		end else if (flag_kill) begin
			item.kind = twrc_pkg::K_KILL;
		end else begin
			item.kind = twrc_pkg::K_NORMAL;
		end

		item.node       = node;
		item.player     = player;
		item.retransmit = flag_retransmit;
		item.rstart     = rstart;
		item.rend       = rstart + $signed({{(twrc_pkg::XTIC_W-8){1'b0}}, tic_count});
		item.retr_tic   = rretr[twrc_pkg::TIC_W-1:0];
	end

endmodule

FILE: rtl/core/twrc_queue.sv
module twrc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  twrc_pkg::item_t wr_item,
	output logic            full,
	input  logic            pop,
	output twrc_pkg::item_t rd_item,
	output logic            empty
);

	twrc_pkg::item_t                    mem_q [twrc_pkg::QDEPTH];
	logic [twrc_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [twrc_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [twrc_pkg::QCNT_W-1:0]        cnt_q;
	logic                               do_push;
	logic                               do_pop;

	assign full    = cnt_q == twrc_pkg::QCNT_W'(twrc_pkg::QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/twrc_back.sv
module twrc_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [twrc_pkg::CNT_NODE_W-1:0]     node_count,
	input  twrc_pkg::item_t                     item,
	input  logic                                item_valid,
	output logic                                item_take,
	input  logic                                res_pop,
	output logic                                res_empty,
	output twrc_pkg::result_t                   res
);

	localparam int NM = twrc_pkg::NODE_MAX;

	logic [twrc_pkg::TIC_W-1:0]   received_q     [NM];
	logic [NM-1:0]                left_q;
	logic [twrc_pkg::CD_W-1:0]    countdown_q    [NM];
	logic [twrc_pkg::TIC_W-1:0]   target_q       [NM];
	logic [NM-1:0]                request_q;
	logic [twrc_pkg::NODE_W-1:0]  node_of_player_q [twrc_pkg::PLAYER_MAX];

	twrc_pkg::result_t                 res_mem_q [twrc_pkg::QDEPTH];
	logic [twrc_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [twrc_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [twrc_pkg::QCNT_W-1:0]       cnt_q;
	logic                              res_full;
	logic                              do_pop;

	twrc_pkg::result_t                 nxt;
	logic                              in_game;
	logic signed [twrc_pkg::XTIC_W-1:0] held;
	logic signed [twrc_pkg::XTIC_W-1:0] skip_w;
	logic signed [twrc_pkg::XTIC_W-1:0] take_w;
	logic [twrc_pkg::CD_W-1:0]         cd;
	logic [twrc_pkg::CD_W-1:0]         cd_nxt;
	logic [twrc_pkg::TIC_W-1:0]        tgt_nxt;
	logic                              req_nxt;
	logic                              set_left;
	logic                              upd_normal;
	logic                              upd_recv;

	assign res_full  = cnt_q == twrc_pkg::QCNT_W'(twrc_pkg::QDEPTH);
	assign res_empty = cnt_q == '0;
	assign item_take = item_valid && !res_full;
	assign do_pop    = res_pop && !res_empty;
	assign res       = res_mem_q[rd_ptr_q];

	always_comb begin
		in_game = ({1'b0, item.node} < node_count) && !left_q[item.node];
		held    = $signed({2'b00, received_q[item.node]});
		skip_w  = held - item.rstart;
		take_w  = item.rend - held;
		cd      = countdown_q[item.node];
		cd_nxt  = cd;
		tgt_nxt = target_q[item.node];
		req_nxt = request_q[item.node];

		set_left   = 1'b0;
		upd_normal = 1'b0;
		upd_recv   = 1'b0;

		nxt.verdict        = twrc_pkg::V_SETUP;
		nxt.expanded_start = item.rstart[twrc_pkg::TIC_W-1:0];
		nxt.skip_count     = '0;
		nxt.take_count     = '0;
		nxt.first_slot     = '0;
		nxt.resend_latched = 1'b0;

		unique case (item.kind)
			twrc_pkg::K_SETUP: begin
				nxt.verdict = twrc_pkg::V_SETUP;
			end
			twrc_pkg::K_EXIT: begin
				set_left    = in_game;
				nxt.verdict = in_game ? twrc_pkg::V_LEFT : twrc_pkg::V_GONE;
			end
			twrc_pkg::K_KILL: begin
				nxt.verdict = twrc_pkg::V_KILL;
			end
			default: begin
				upd_normal = 1'b1;
				if (cd == '0 && item.retransmit) begin
					tgt_nxt            = item.retr_tic;
					cd_nxt             = twrc_pkg::RELOAD;
					nxt.resend_latched = 1'b1;
				end else if (cd != '0) begin
					cd_nxt = cd - 1'b1;
				end
				if (item.rend == held) begin
					nxt.verdict = twrc_pkg::V_DUP;
				end else if (item.rend < held) begin
					nxt.verdict = twrc_pkg::V_ORDER;
				end else if (item.rstart > held) begin
					req_nxt     = 1'b1;
					nxt.verdict = twrc_pkg::V_MISSED;
				end else begin
					req_nxt        = 1'b0;
					upd_recv       = 1'b1;
					nxt.skip_count = skip_w[7:0];
					nxt.take_count = take_w[7:0];
					nxt.first_slot = received_q[item.node][twrc_pkg::SLOT_W-1:0];
					nxt.verdict    = twrc_pkg::V_ACCEPT;
				end
			end
		endcase

		nxt.resend_from   = tgt_nxt;
		nxt.resend_needed = req_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			request_q <= '0;
			for (int i = 0; i < NM; i++) begin
				received_q[i]  <= '0;
				countdown_q[i] <= '0;
				target_q[i]    <= '0;
			end
			for (int i = 0; i < twrc_pkg::PLAYER_MAX; i++) begin
				node_of_player_q[i] <= '0;
			end
		end else if (item_take) begin
			if (set_left) begin
				left_q[item.node] <= 1'b1;
			end
			if (upd_normal) begin
				node_of_player_q[item.player] <= item.node;
				countdown_q[item.node]        <= cd_nxt;
				target_q[item.node]           <= tgt_nxt;
				request_q[item.node]          <= req_nxt;
			end
			if (upd_recv) begin
				received_q[item.node] <= item.rend[twrc_pkg::TIC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			res_mem_q[wr_ptr_q] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (item_take) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (item_take && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !item_take) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/tic_window_receive_check.sv
// Receive-side tic window check. Each word pushed in is one packet header; each word
// popped out is its verdict with the expanded first tic, the skip/take counts and ring
// slot of an accepted packet, and the sending node's resend state after the packet.
// Low tic bytes are expanded against local_tic within plus or minus 64. Words flow
// through a front stage (flag priority and tic expansion) into a two-word queue, then
// a back stage that reads the node's receive state combinationally, updates it when it
// takes the word and stores the result in a two-word result queue. Sustained rate is one
// word per clock while the result queue is not full and words are waiting; a pushed word
// is registered in the queue and its result in the result queue before it is popped.
// Write node_count through cfg_wr_en/cfg_wr_data only while no words are in flight; it
// resets to 1, and all per-node state resets to zero.
module tic_window_receive_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [twrc_pkg::NODE_W-1:0]         node,
	input  logic [twrc_pkg::PLAYER_W-1:0]       player,
	input  logic [7:0]                          start_tic_low,
	input  logic [7:0]                          tic_count,
	input  logic [7:0]                          retransmit_low,
	input  logic                                flag_setup,
	input  logic                                flag_exit,
	input  logic                                flag_kill,
	input  logic                                flag_retransmit,
	input  logic [twrc_pkg::TIC_W-1:0]          local_tic,
	input  logic                                cfg_wr_en,
	input  logic [twrc_pkg::CNT_NODE_W-1:0]     cfg_wr_data,
	output logic                                empty,
	input  logic                                pop,
	output logic [2:0]                          verdict,
	output logic [twrc_pkg::TIC_W-1:0]          expanded_start,
	output logic [7:0]                          skip_count,
	output logic [7:0]                          take_count,
	output logic [twrc_pkg::SLOT_W-1:0]         first_slot,
	output logic [twrc_pkg::TIC_W-1:0]          resend_from,
	output logic                                resend_latched,
	output logic                                resend_needed
);

	logic [twrc_pkg::CNT_NODE_W-1:0] node_count_q;
	twrc_pkg::item_t                 front_item;
	twrc_pkg::item_t                 head_item;
	logic                            head_empty;
	logic                            head_take;
	twrc_pkg::result_t               res;

	// hold the session node count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= twrc_pkg::CNT_NODE_W'(1);
		end else if (cfg_wr_en) begin
			node_count_q <= cfg_wr_data;
		end
	end

	// classify the header and expand its tic bytes
	twrc_front u_front (
		.flag_setup      (flag_setup),
		.flag_exit       (flag_exit),
		.flag_kill       (flag_kill),
		.flag_retransmit (flag_retransmit),
		.node            (node),
		.player          (player),
		.start_tic_low   (start_tic_low),
		.tic_count       (tic_count),
		.retransmit_low  (retransmit_low),
		.local_tic       (local_tic),
		.item            (front_item)
	);

	// decouple the front from the back
	twrc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.full    (full),
		.pop     (head_take),
		.rd_item (head_item),
		.empty   (head_empty)
	);

	// apply the word to the node state and queue its result
	twrc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_count (node_count_q),
		.item       (head_item),
		.item_valid (!head_empty),
		.item_take  (head_take),
		.res_pop    (pop),
		.res_empty  (empty),
		.res        (res)
	);

	assign verdict        = res.verdict;
	assign expanded_start = res.expanded_start;
	assign skip_count     = res.skip_count;
	assign take_count     = res.take_count;
	assign first_slot     = res.first_slot;
	assign resend_from    = res.resend_from;
	assign resend_latched = res.resend_latched;
	assign resend_needed  = res.resend_needed;

`ifndef SYNTHESIS
	// an accepted packet always brings at least one new tic
	a_accept_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && verdict == twrc_pkg::V_ACCEPT) |-> take_count != 8'd0)
		else $error("accepted packet with zero take count");

	// skip, take and slot are only reported for accepted packets
	a_counts_only_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && verdict != twrc_pkg::V_ACCEPT) |->
		(skip_count == 8'd0 && take_count == 8'd0 && first_slot == '0))
		else $error("counts reported on a packet that was not accepted");

	// a retransmit request is only latched on an ordinary data packet
	a_latch_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && resend_latched) |->
		(verdict == twrc_pkg::V_DUP || verdict == twrc_pkg::V_ORDER ||
		 verdict == twrc_pkg::V_MISSED || verdict == twrc_pkg::V_ACCEPT))
		else $error("retransmit latched on setup, exit or kill packet");

	// a missed packet leaves the resend flag raised, an accepted one clears it
	a_resend_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (verdict == twrc_pkg::V_MISSED || verdict == twrc_pkg::V_ACCEPT)) |->
		resend_needed == (verdict == twrc_pkg::V_MISSED))
		else $error("resend flag inconsistent with verdict");
`endif

endmodule
